/* rtl/nskt_pkg.sv */
// nskt_pkg: shared types and constants of the number suffix key table
// operation and outcome codes, controller state, command and status structs
// no dependencies
package nskt_pkg;

	localparam int CH_W      = 8;
	localparam int TAG_W     = 16;
	localparam int CAP_W     = 10;
	localparam int CNT_OUT_W = 10;
	localparam int OP_W      = 2;
	localparam int OUTC_W    = 3;

	localparam logic [CAP_W-1:0] CAP_RESET  = 10'd500;
	localparam logic [CH_W-1:0]  ASCII_ZERO = 8'd48;
	localparam logic [CH_W-1:0]  ASCII_NINE = 8'd57;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_MARK   = 2'd3
	} op_t;

	typedef enum logic [OUTC_W-1:0] {
		RES_INSERTED = 3'd0,
		RES_DROPPED  = 3'd1,
		RES_HIT      = 3'd2,
		RES_MISS     = 3'd3,
		RES_CLEARED  = 3'd4,
		RES_MARKED   = 3'd5
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_READ = 2'd1,
		ST_CMP  = 2'd2,
		ST_EMIT = 2'd3
	} state_t;

	typedef struct packed {
		logic     acc_step;
		logic     acc_clear;
		logic     tbl_clear;
		logic     tbl_mark;
		logic     tbl_write;
		logic     scan_start;
		logic     scan_next;
		logic     rd_en;
		logic     pend_set;
		outcome_t pend_code;
		logic     out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic key_empty;
		logic full;
		logic tbl_valid;
		logic cnt_zero;
		logic hit;
		logic at_end;
		logic out_busy;
	} dp_stat_t;

endpackage

/* rtl/nskt_item_if.sv */
// nskt_item_if: input channel of the number suffix key table
// valid/ready handshake with op, character, last flag and entry tag
// depends on nskt_pkg for field widths
interface nskt_item_if;
	logic                         valid;
	logic                         ready;
	logic [nskt_pkg::OP_W-1:0]    op;
	logic [nskt_pkg::CH_W-1:0]    ch;
	logic                         last_char;
	logic [nskt_pkg::TAG_W-1:0]   entry_tag;

	modport source(output valid, output op, output ch, output last_char,
		output entry_tag, input ready);
	modport sink(input valid, input op, input ch, input last_char,
		input entry_tag, output ready);
endinterface

/* rtl/nskt_result_if.sv */
// nskt_result_if: result channel of the number suffix key table
// valid/ready handshake with outcome, found tag, entry count and valid flag
// depends on nskt_pkg for field widths
interface nskt_result_if;
	logic                            valid;
	logic                            ready;
	logic [nskt_pkg::OUTC_W-1:0]     outcome;
	logic [nskt_pkg::TAG_W-1:0]      found_tag;
	logic [nskt_pkg::CNT_OUT_W-1:0]  entry_count;
	logic                            table_valid;

	modport source(output valid, output outcome, output found_tag,
		output entry_count, output table_valid, input ready);
	modport sink(input valid, input outcome, input found_tag,
		input entry_count, input table_valid, output ready);
endinterface

/* rtl/nskt_cfg_if.sv */
// nskt_cfg_if: configuration write channel carrying capacity_limit
// valid/ready handshake, no address since there is a single register
// depends on nskt_pkg for the data width
interface nskt_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [nskt_pkg::CAP_W-1:0]   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/number_suffix_key_table.sv */
// number_suffix_key_table: characters that are not the last are taken one per cycle while the
// controller is idle; an insert's last character, clear or mark-valid goes to the emit state,
// whose result the output register loads once free; a lookup walks the table from entry 0, a
// memory read and a compare per entry, up to the first hit or the last held entry; a stalled
// result holds the input off once the next result waits to emit; arst_n clears the accumulator,
// count, valid flag, capacity (to 500) and controller; key and tag memories are not cleared
module number_suffix_key_table #(
	parameter int ENTRIES    = 512,
	parameter int KEY_DIGITS = 9,
	parameter int DIGIT_CAP  = 47
) (
	input  logic          clk,
	input  logic          arst_n,
	nskt_item_if.sink     item,
	nskt_result_if.source result,
	nskt_cfg_if.sink      cfg
);

	nskt_pkg::ctrl_cmd_t cmd;
	nskt_pkg::dp_stat_t  stat;

	nskt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.op         (item.op),
		.last_char  (item.last_char),
		.stat       (stat),
		.item_ready (item.ready),
		.cmd        (cmd)
	);

	nskt_dp #(
		.ENTRIES    (ENTRIES),
		.KEY_DIGITS (KEY_DIGITS),
		.DIGIT_CAP  (DIGIT_CAP)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.ch              (item.ch),
		.entry_tag       (item.entry_tag),
		.cfg_valid       (cfg.valid),
		.cfg_data        (cfg.data),
		.cfg_ready       (cfg.ready),
		.out_ready       (result.ready),
		.out_valid       (result.valid),
		.out_outcome     (result.outcome),
		.out_found_tag   (result.found_tag),
		.out_entry_count (result.entry_count),
		.out_table_valid (result.table_valid)
	);

endmodule

/* rtl/nskt_ctrl.sv */
// nskt_ctrl: controller state machine of the number suffix key table
// sequences accumulate, insert, clear, mark-valid, lookup scan and result hand-off
// depends on nskt_pkg for state, command and status types
module nskt_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic [nskt_pkg::OP_W-1:0] op,
	input  logic                      last_char,
	input  nskt_pkg::dp_stat_t        stat,
	output logic                      item_ready,
	output nskt_pkg::ctrl_cmd_t       cmd
);

	nskt_pkg::state_t state_q;
	nskt_pkg::state_t state_nx;
	nskt_pkg::op_t    op_in;

	assign op_in = nskt_pkg::op_t'(op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nskt_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx       = state_q;
		item_ready     = 1'b0;
		cmd            = '0;
		cmd.pend_code  = nskt_pkg::RES_MISS;
		case (state_q)
			nskt_pkg::ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					case (op_in)
						nskt_pkg::OP_CLEAR: begin
							cmd.tbl_clear = 1'b1;
							cmd.pend_set  = 1'b1;
							cmd.pend_code = nskt_pkg::RES_CLEARED;
							state_nx      = nskt_pkg::ST_EMIT;
						end
						nskt_pkg::OP_MARK: begin
							cmd.tbl_mark  = 1'b1;
							cmd.pend_set  = 1'b1;
							cmd.pend_code = nskt_pkg::RES_MARKED;
							state_nx      = nskt_pkg::ST_EMIT;
						end
						default: begin
							cmd.acc_step = 1'b1;
							if (last_char) begin
								cmd.acc_clear = 1'b1;
								if (op_in == nskt_pkg::OP_INSERT) begin
									cmd.pend_set = 1'b1;
									if (stat.key_empty || stat.full) begin
										cmd.pend_code = nskt_pkg::RES_DROPPED;
									end else begin
										cmd.tbl_write = 1'b1;
										cmd.pend_code = nskt_pkg::RES_INSERTED;
									end
									state_nx = nskt_pkg::ST_EMIT;
								end else if (stat.key_empty || !stat.tbl_valid ||
										stat.cnt_zero) begin
									cmd.pend_set  = 1'b1;
									cmd.pend_code = nskt_pkg::RES_MISS;
									state_nx      = nskt_pkg::ST_EMIT;
								end else begin
									cmd.scan_start = 1'b1;
									state_nx       = nskt_pkg::ST_READ;
								end
							end
						end
					endcase
				end
			end
			nskt_pkg::ST_READ: begin
				cmd.rd_en = 1'b1;
				state_nx  = nskt_pkg::ST_CMP;
			end
			nskt_pkg::ST_CMP: begin
				if (stat.hit) begin
					cmd.pend_set  = 1'b1;
					cmd.pend_code = nskt_pkg::RES_HIT;
					state_nx      = nskt_pkg::ST_EMIT;
				end else if (stat.at_end) begin
					cmd.pend_set  = 1'b1;
					cmd.pend_code = nskt_pkg::RES_MISS;
					state_nx      = nskt_pkg::ST_EMIT;
				end else begin
					cmd.scan_next = 1'b1;
					state_nx      = nskt_pkg::ST_READ;
				end
			end
			nskt_pkg::ST_EMIT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_nx     = nskt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = nskt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/nskt_dp.sv */
// nskt_dp: datapath of the number suffix key table
// digit accumulator, key/tag memory, scan index, counters and output register
// depends on nskt_pkg for command, status and code types
module nskt_dp #(
	parameter int ENTRIES    = 512,
	parameter int KEY_DIGITS = 9,
	parameter int DIGIT_CAP  = 47
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  nskt_pkg::ctrl_cmd_t              cmd,
	output nskt_pkg::dp_stat_t               stat,
	input  logic [nskt_pkg::CH_W-1:0]        ch,
	input  logic [nskt_pkg::TAG_W-1:0]       entry_tag,
	input  logic                             cfg_valid,
	input  logic [nskt_pkg::CAP_W-1:0]       cfg_data,
	output logic                             cfg_ready,
	input  logic                             out_ready,
	output logic                             out_valid,
	output logic [nskt_pkg::OUTC_W-1:0]      out_outcome,
	output logic [nskt_pkg::TAG_W-1:0]       out_found_tag,
	output logic [nskt_pkg::CNT_OUT_W-1:0]   out_entry_count,
	output logic                             out_table_valid
);

	localparam int WIN_BITS = 4 * KEY_DIGITS;
	localparam int LEN_W    = $clog2(KEY_DIGITS + 1);
	localparam int KEY_W    = WIN_BITS + LEN_W;
	localparam int ADDR_W   = $clog2(ENTRIES);
	localparam int CNT_W    = $clog2(ENTRIES + 1);
	localparam int SEEN_W   = $clog2(DIGIT_CAP + 1);
	localparam int CMP_W    = (CNT_W > nskt_pkg::CAP_W) ? CNT_W : nskt_pkg::CAP_W;

	logic [WIN_BITS-1:0]            window_q;
	logic [SEEN_W-1:0]              seen_q;
	logic [CNT_W-1:0]               count_q;
	logic                           flag_q;
	logic [nskt_pkg::CAP_W-1:0]     cap_q;
	logic [ADDR_W-1:0]              idx_q;
	logic [KEY_W-1:0]               key_q;
	logic [KEY_W-1:0]               rd_key_q;
	logic [nskt_pkg::TAG_W-1:0]     rd_tag_q;
	nskt_pkg::outcome_t             pend_code_q;
	logic [nskt_pkg::TAG_W-1:0]     pend_tag_q;
	logic                           out_valid_q;
	logic [nskt_pkg::OUTC_W-1:0]    out_outcome_q;
	logic [nskt_pkg::TAG_W-1:0]     out_tag_q;
	logic [nskt_pkg::CNT_OUT_W-1:0] out_count_q;
	logic                           out_flag_q;

	logic [KEY_W-1:0]               key_mem [ENTRIES];
	logic [nskt_pkg::TAG_W-1:0]     tag_mem [ENTRIES];

	logic                           digit_ok;
	logic [nskt_pkg::CH_W-1:0]      digit_val;
	logic [WIN_BITS-1:0]            window_nx;
	logic [SEEN_W-1:0]              seen_nx;
	logic [LEN_W-1:0]               len_nx;
	logic [KEY_W-1:0]               key_nx;
	logic [CMP_W-1:0]               limit;

	// accumulator view including the character on the port this cycle
	always_comb begin
		digit_ok  = (ch inside {[nskt_pkg::ASCII_ZERO:nskt_pkg::ASCII_NINE]}) &&
			(seen_q < SEEN_W'(DIGIT_CAP));
		digit_val = ch - nskt_pkg::ASCII_ZERO;
		window_nx = digit_ok ? WIN_BITS'({window_q, digit_val[3:0]}) : window_q;
		seen_nx   = digit_ok ? seen_q + SEEN_W'(1) : seen_q;
		len_nx    = (seen_nx < SEEN_W'(KEY_DIGITS)) ? LEN_W'(seen_nx) : LEN_W'(KEY_DIGITS);
		key_nx    = {len_nx, window_nx};
		limit     = (CMP_W'(cap_q) < CMP_W'(ENTRIES)) ? CMP_W'(cap_q) : CMP_W'(ENTRIES);
	end

	always_comb begin
		stat.key_empty = (seen_nx == '0);
		stat.full      = (CMP_W'(count_q) >= limit);
		stat.tbl_valid = flag_q;
		stat.cnt_zero  = (count_q == '0);
		stat.hit       = (rd_key_q == key_q);
		stat.at_end    = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
		stat.out_busy  = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			seen_q   <= '0;
			count_q  <= '0;
			flag_q   <= 1'b0;
			cap_q    <= nskt_pkg::CAP_RESET;
			idx_q    <= '0;
		end else begin
			if (cmd.acc_clear) begin
				window_q <= '0;
				seen_q   <= '0;
			end else if (cmd.acc_step) begin
				window_q <= window_nx;
				seen_q   <= seen_nx;
			end
			if (cmd.tbl_clear) begin
				count_q <= '0;
				flag_q  <= 1'b0;
			end else if (cmd.tbl_mark) begin
				flag_q <= 1'b1;
			end else if (cmd.tbl_write) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.scan_start) begin
				idx_q <= '0;
			end else if (cmd.scan_next) begin
				idx_q <= idx_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tbl_write) begin
			key_mem[count_q[ADDR_W-1:0]] <= key_nx;
			tag_mem[count_q[ADDR_W-1:0]] <= entry_tag;
		end
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[idx_q];
			rd_tag_q <= tag_mem[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			key_q <= key_nx;
		end
		if (cmd.pend_set) begin
			pend_code_q <= cmd.pend_code;
			pend_tag_q  <= (cmd.pend_code == nskt_pkg::RES_HIT) ? rd_tag_q : '0;
		end
		if (cmd.out_load) begin
			out_outcome_q <= pend_code_q;
			out_tag_q     <= pend_tag_q;
			out_count_q   <= nskt_pkg::CNT_OUT_W'(count_q);
			out_flag_q    <= flag_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign cfg_ready       = 1'b1;
	assign out_valid       = out_valid_q;
	assign out_outcome     = out_outcome_q;
	assign out_found_tag   = out_tag_q;
	assign out_entry_count = out_count_q;
	assign out_table_valid = out_flag_q;

endmodule

/* rtl/nskt_chk.sv */
// nskt_chk: port-level checks of the number suffix key table
// bound to number_suffix_key_table; depends on nskt_pkg for codes
module nskt_chk (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_ready,
	input  logic [nskt_pkg::OP_W-1:0]       item_op,
	input  logic                            res_valid,
	input  logic                            res_ready,
	input  logic [nskt_pkg::OUTC_W-1:0]     res_outcome,
	input  logic [nskt_pkg::TAG_W-1:0]      res_found_tag,
	input  logic [nskt_pkg::CNT_OUT_W-1:0]  res_entry_count,
	input  logic                            res_table_valid
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_outcome) &&
			$stable(res_found_tag) && $stable(res_entry_count) &&
			$stable(res_table_valid))
		else $error("stalled result changed");

	// a clear transaction is followed by a cycle that takes no new item
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && (item_op == nskt_pkg::OP_CLEAR) |=> !item_ready)
		else $error("item taken right after clear");

	a_cleared_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_outcome == nskt_pkg::RES_CLEARED) |->
			(res_entry_count == '0) && !res_table_valid)
		else $error("clear result shows entries or valid flag");

	a_marked_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_outcome == nskt_pkg::RES_MARKED) |-> res_table_valid)
		else $error("mark valid result without valid flag");

	a_tag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_outcome != nskt_pkg::RES_HIT) |-> (res_found_tag == '0))
		else $error("nonzero tag on a result other than a hit");

endmodule

bind number_suffix_key_table nskt_chk u_nskt_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.item_op         (item.op),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.res_outcome     (result.outcome),
	.res_found_tag   (result.found_tag),
	.res_entry_count (result.entry_count),
	.res_table_valid (result.table_valid)
);

/* tb/sv/number_suffix_key_table_test.sv */
// number_suffix_key_table_test: self-checking bench for the number suffix key table
// drives characters, clear and mark-valid, predicts every reply and compares it field by field
// depends on nskt_pkg, nskt_item_if, nskt_result_if, nskt_cfg_if and number_suffix_key_table
`timescale 1ns / 1ps

module number_suffix_key_table_test;

	localparam int CLK_PERIOD     = 10;
	localparam int TBL_ENTRIES    = 512;
	localparam int KEY_DIGITS     = 9;
	localparam int DIGIT_CAP      = 47;
	localparam int WIN_W          = 4 * KEY_DIGITS;
	localparam int DRAIN_CYCLES   = 8;
	localparam int END_CYCLES     = 20;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 6000;

	typedef struct packed {
		nskt_pkg::outcome_t                   outcome;
		logic [nskt_pkg::TAG_W-1:0]           tag;
		logic [nskt_pkg::CNT_OUT_W-1:0]       count;
		logic                                 valid;
	} table_reply_t;

	logic clk = 1'b0;
	logic arst_n;

	nskt_item_if   item_ch();
	nskt_result_if result_ch();
	nskt_cfg_if    cfg_ch();

	number_suffix_key_table #(
		.ENTRIES   (TBL_ENTRIES),
		.KEY_DIGITS(KEY_DIGITS),
		.DIGIT_CAP (DIGIT_CAP)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// predicted table contents
	logic [WIN_W+3:0]               key_mem [TBL_ENTRIES];
	logic [nskt_pkg::TAG_W-1:0]     tag_mem [TBL_ENTRIES];
	int                             held_count;
	logic                           marked_valid;
	logic [WIN_W-1:0]               digit_buf;
	int                             digit_total;
	logic [nskt_pkg::CAP_W-1:0]     capacity;

	table_reply_t pending_replies[$];
	string        number_pool[$];

	int   items_sent = 0;
	int   failures = 0;
	int   quiet_cycles = 0;
	bit   idle_en = 1'b1;
	bit   hold_request = 1'b0;

	function automatic void reset_predictor();
		held_count = 0;
		marked_valid = 1'b0;
		digit_buf = '0;
		digit_total = 0;
		capacity = nskt_pkg::CAP_RESET;
	endfunction

	function automatic void predict_table_op(nskt_pkg::op_t op, logic [nskt_pkg::CH_W-1:0] ch,
		logic is_last, logic [nskt_pkg::TAG_W-1:0] tag);
		logic [nskt_pkg::CH_W-1:0] dv;
		logic [WIN_W+3:0]          key;
		int                        len;
		int                        limit;
		int                        idx;
		bit                        reply_due;
		bit                        found;
		table_reply_t              r;
		r = '0;
		reply_due = 1'b0;
		found = 1'b0;
		case (op)
			nskt_pkg::OP_CLEAR: begin
				held_count = 0;
				marked_valid = 1'b0;
				r.outcome = nskt_pkg::RES_CLEARED;
				reply_due = 1'b1;
			end
			nskt_pkg::OP_MARK: begin
				marked_valid = 1'b1;
				r.outcome = nskt_pkg::RES_MARKED;
				reply_due = 1'b1;
			end
			default: begin
				if (ch >= nskt_pkg::ASCII_ZERO && ch <= nskt_pkg::ASCII_NINE &&
					digit_total < DIGIT_CAP) begin
					dv = ch - nskt_pkg::ASCII_ZERO;
					digit_buf = {digit_buf[WIN_W-5:0], dv[3:0]};
					digit_total++;
				end
				if (is_last) begin
					len = (digit_total < KEY_DIGITS) ? digit_total : KEY_DIGITS;
					key = {len[3:0], digit_buf};
					limit = (capacity < TBL_ENTRIES) ? int'(capacity) : TBL_ENTRIES;
					digit_buf = '0;
					digit_total = 0;
					reply_due = 1'b1;
					if (op == nskt_pkg::OP_INSERT) begin
						if (len == 0 || held_count >= limit) begin
							r.outcome = nskt_pkg::RES_DROPPED;
						end else begin
							key_mem[held_count] = key;
							tag_mem[held_count] = tag;
							held_count++;
							r.outcome = nskt_pkg::RES_INSERTED;
						end
					end else begin
						r.outcome = nskt_pkg::RES_MISS;
						if (len != 0 && marked_valid) begin
							// first equal key wins
							for (idx = 0; idx < held_count; idx++) begin
								if (!found && key_mem[idx] == key) begin
									found = 1'b1;
									r.outcome = nskt_pkg::RES_HIT;
									r.tag = tag_mem[idx];
								end
							end
						end
					end
				end
			end
		endcase
		if (reply_due) begin
			r.count = held_count[nskt_pkg::CNT_OUT_W-1:0];
			r.valid = marked_valid;
			pending_replies.push_back(r);
		end
	endfunction

	function automatic string random_digits(int n);
		string s;
		int i;
		s = "";
		for (i = 0; i < n; i++)
			s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		return s;
	endfunction

	function automatic logic [nskt_pkg::CH_W-1:0] pick_separator();
		logic [nskt_pkg::CH_W-1:0] c;
		case ($urandom_range(0, 5))
			0: c = " ";
			1: c = "-";
			2: c = "+";
			3: c = "(";
			4: c = ")";
			default: begin
				c = 8'($urandom_range(0, 255));
				if (c >= nskt_pkg::ASCII_ZERO && c <= nskt_pkg::ASCII_NINE)
					c = c ^ 8'h80;
			end
		endcase
		return c;
	endfunction

	// one input transaction, with an optional idle burst in front
	task automatic send_item(nskt_pkg::op_t op, logic [nskt_pkg::CH_W-1:0] ch, logic is_last,
		logic [nskt_pkg::TAG_W-1:0] tag);
		if (idle_en && $urandom_range(0, 7) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		item_ch.valid     <= 1'b1;
		item_ch.op        <= op;
		item_ch.ch        <= ch;
		item_ch.last_char <= is_last;
		item_ch.entry_tag <= tag;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
		predict_table_op(op, ch, is_last, tag);
	endtask

	// digits with random punctuation, final character flagged last; mix_pct mixes in other ops
	task automatic send_number(nskt_pkg::op_t op, string digits, logic [nskt_pkg::TAG_W-1:0] tag,
		int mix_pct);
		logic [nskt_pkg::CH_W-1:0] text[$];
		nskt_pkg::op_t char_op;
		int  i;
		int  last_idx;
		text = {};
		for (i = 0; i < digits.len(); i++) begin
			if ($urandom_range(0, 3) == 0)
				text.push_back(pick_separator());
			text.push_back(digits.getc(i));
		end
		if (text.size() == 0 || $urandom_range(0, 5) == 0)
			text.push_back(pick_separator());
		last_idx = text.size() - 1;
		for (i = 0; i <= last_idx; i++) begin
			char_op = op;
			if (i != last_idx && $urandom_range(0, 99) < mix_pct)
				char_op = (op == nskt_pkg::OP_INSERT) ? nskt_pkg::OP_LOOKUP : nskt_pkg::OP_INSERT;
			if (i != last_idx && $urandom_range(0, 99) < mix_pct)
				send_item($urandom_range(0, 3) == 0 ? nskt_pkg::OP_CLEAR : nskt_pkg::OP_MARK,
					8'($urandom), 1'($urandom), 16'($urandom));
			send_item(char_op, text[i], i == last_idx, (i == last_idx) ? tag : 16'($urandom));
		end
	endtask

	task automatic set_capacity(logic [nskt_pkg::CAP_W-1:0] value);
		item_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		capacity = value;
	endtask

	task automatic test_basics();
		send_item(nskt_pkg::OP_LOOKUP, "5", 1'b1, 16'h0000);
		send_item(nskt_pkg::OP_INSERT, 8'h00, 1'b0, 16'hFFFF);
		send_item(nskt_pkg::OP_INSERT, 8'hFF, 1'b1, 16'hFFFF);
		send_item(nskt_pkg::OP_LOOKUP, "-", 1'b1, 16'h0000);
		send_number(nskt_pkg::OP_INSERT, "5551234567", 16'hFFFF, 0);
		send_number(nskt_pkg::OP_LOOKUP, "5551234567", 16'h0000, 0);
		send_item(nskt_pkg::OP_MARK, 8'hFF, 1'b1, 16'hFFFF);
		send_number(nskt_pkg::OP_LOOKUP, "15551234567", 16'h0000, 0);
		send_item(nskt_pkg::OP_INSERT, "0", 1'b1, 16'h0000);
		send_item(nskt_pkg::OP_LOOKUP, "0", 1'b1, 16'hFFFF);
		// ops switch mid-number, the op with the last character decides
		send_item(nskt_pkg::OP_INSERT, "1", 1'b0, 16'h1234);
		send_item(nskt_pkg::OP_LOOKUP, "2", 1'b0, 16'h1234);
		send_item(nskt_pkg::OP_MARK, "3", 1'b1, 16'h0000);
		send_item(nskt_pkg::OP_INSERT, "4", 1'b1, 16'hA5A5);
		send_item(nskt_pkg::OP_LOOKUP, "4", 1'b1, 16'h0000);
		send_item(nskt_pkg::OP_CLEAR, "9", 1'b1, 16'hFFFF);
		send_item(nskt_pkg::OP_LOOKUP, "0", 1'b1, 16'h0000);
	endtask

	task automatic test_digit_cap();
		string long_num;
		long_num = random_digits(50);
		send_number(nskt_pkg::OP_INSERT, long_num, 16'($urandom), 0);
		send_item(nskt_pkg::OP_MARK, 8'($urandom), 1'($urandom), 16'($urandom));
		// digits past the cap are ignored
		send_number(nskt_pkg::OP_LOOKUP, {long_num.substr(0, DIGIT_CAP - 1), random_digits(5)},
			16'h0000, 0);
		send_number(nskt_pkg::OP_LOOKUP, long_num.substr(DIGIT_CAP - KEY_DIGITS, DIGIT_CAP - 1),
			16'h0000, 0);
		send_number(nskt_pkg::OP_LOOKUP, long_num.substr(DIGIT_CAP - 8, DIGIT_CAP - 1),
			16'h0000, 0);
		send_number(nskt_pkg::OP_INSERT, random_digits(DIGIT_CAP), 16'($urandom), 0);
		send_number(nskt_pkg::OP_INSERT, random_digits(DIGIT_CAP + 1), 16'($urandom), 0);
	endtask

	task automatic test_capacity();
		int i;
		set_capacity(10'd1);
		send_item(nskt_pkg::OP_CLEAR, 8'h00, 1'b0, 16'h0000);
		send_item(nskt_pkg::OP_INSERT, "1", 1'b1, 16'($urandom));
		send_item(nskt_pkg::OP_INSERT, "2", 1'b1, 16'($urandom));
		set_capacity(10'd512);
		send_item(nskt_pkg::OP_CLEAR, 8'h00, 1'b0, 16'h0000);
		send_item(nskt_pkg::OP_MARK, 8'h00, 1'b0, 16'h0000);
		for (i = 0; i < TBL_ENTRIES - 1; i++)
			send_item(nskt_pkg::OP_INSERT, nskt_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)), 1'b1,
				16'($urandom));
		send_number(nskt_pkg::OP_INSERT, "42", 16'hBEEF, 0);
		// table full at the hard entry limit
		send_item(nskt_pkg::OP_INSERT, "7", 1'b1, 16'($urandom));
		send_number(nskt_pkg::OP_LOOKUP, "42", 16'h0000, 0);
		send_number(nskt_pkg::OP_LOOKUP, "123", 16'h0000, 0);
		send_item(nskt_pkg::OP_CLEAR, 8'hFF, 1'b1, 16'hFFFF);
	endtask

	task automatic run_random_items(int n);
		int            stop_at;
		int            pick;
		int            nd;
		string         digits;
		nskt_pkg::op_t num_op;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			// keep table walks short
			if (held_count >= 40 && $urandom_range(0, 3) == 0)
				pick = 0;
			if (pick < 5) begin
				send_item(nskt_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom));
			end else if (pick < 13) begin
				send_item(nskt_pkg::OP_MARK, 8'($urandom), 1'($urandom), 16'($urandom));
			end else if (pick < 20) begin
				send_item($urandom_range(0, 1) ? nskt_pkg::OP_INSERT : nskt_pkg::OP_LOOKUP,
					8'($urandom), $urandom_range(0, 3) == 0, 16'($urandom));
			end else begin
				num_op = ($urandom_range(0, 99) < 55) ? nskt_pkg::OP_INSERT : nskt_pkg::OP_LOOKUP;
				if (number_pool.size() != 0 && $urandom_range(0, 99) < 60) begin
					digits = number_pool[$urandom_range(0, number_pool.size() - 1)];
					// extra leading digits keep the same nine-digit suffix
					if (digits.len() >= KEY_DIGITS && digits.len() <= 40 &&
						$urandom_range(0, 2) == 0)
						digits = {random_digits($urandom_range(1, 4)), digits};
				end else begin
					nd = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 55) :
						$urandom_range(0, 12);
					digits = random_digits(nd);
				end
				send_number(num_op, digits, 16'($urandom), 4);
				if (num_op == nskt_pkg::OP_INSERT && digits.len() != 0) begin
					number_pool.push_back(digits);
					if (number_pool.size() > 24)
						void'(number_pool.pop_front());
				end
			end
		end
	endtask

	task automatic test_random_traffic();
		set_capacity(10'($urandom_range(2, 30)));
		run_random_items(200);
		set_capacity(10'($urandom_range(1, 512)));
		run_random_items(200);
		set_capacity(10'd512);
		run_random_items(200);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		int i;
		idle_en = 1'b0;
		hold_request = 1'b1;
		send_item(nskt_pkg::OP_MARK, 8'($urandom), 1'($urandom), 16'($urandom));
		for (i = 0; i < 40; i++)
			send_item(nskt_pkg::OP_INSERT, nskt_pkg::ASCII_ZERO + 8'($urandom_range(0, 9)), 1'b1,
				16'($urandom));
		send_item(nskt_pkg::OP_CLEAR, 8'($urandom), 1'($urandom), 16'($urandom));
		idle_en = 1'b1;
	endtask

	task automatic test_steady_stream();
		set_capacity(nskt_pkg::CAP_RESET);
		idle_en = 1'b0;
		run_random_items(250);
	endtask

	// result sink with random stall bursts and one long hold-off
	initial begin
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		table_reply_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_replies.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected result: outcome %0d tag %h count %0d valid %0b",
						result_ch.outcome, result_ch.found_tag, result_ch.entry_count,
						result_ch.table_valid);
			end else begin
				want = pending_replies.pop_front();
				if (result_ch.outcome !== want.outcome || result_ch.found_tag !== want.tag ||
					result_ch.entry_count !== want.count ||
					result_ch.table_valid !== want.valid) begin
					failures++;
					if (failures <= 10)
						$display("mismatch: expected outcome %0d tag %h count %0d valid %0b, %s",
							want.outcome, want.tag, want.count, want.valid,
							$sformatf("got outcome %0d tag %h count %0d valid %0b",
								result_ch.outcome, result_ch.found_tag,
								result_ch.entry_count, result_ch.table_valid));
				end
			end
		end
	end

	// cycles without any transaction
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n            <= 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.op        <= nskt_pkg::OP_INSERT;
		item_ch.ch        <= '0;
		item_ch.last_char <= 1'b0;
		item_ch.entry_tag <= '0;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.data       <= '0;
		reset_predictor();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basics();
		test_digit_cap();
		test_capacity();
		test_random_traffic();
		test_backpressure();
		test_steady_stream();

		item_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
